### hdl/gbfp_pkg.sv
// Shared types and constants for the binary GNSS frame parser.
package gbfp_pkg;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] IdLong     = 8'd7;
  localparam logic [7:0] IdShort    = 8'd2;

  localparam logic [15:0] LongLenReset  = 16'd92;
  localparam logic [15:0] ShortLenReset = 16'd28;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_LONG_LEN  = 1'b0,
    CFG_SHORT_LEN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
  } result_t;

endpackage

### hdl/gnss_binary_frame_parser_top.sv
// Top level of the binary GNSS frame parser with 8-bit Fletcher check.
// One received byte is taken per request, one per clock cycle when the output side keeps
// up; the byte is parsed in the cycle it is accepted and its result, if any, sits in the
// result register from the next cycle. Input ready is high whenever the result register
// is empty or being read, so a stalled output stops input only while a result is pending.
// Length registers are written through cfg_we_i, cfg_index_i (0 long, 1 short) and
// cfg_data_i; the expected length is latched when the id byte of a frame arrives.
module gnss_binary_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import gbfp_pkg::*;

  result_t parse_res, out_res;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  gbfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (parse_res)
  );

  gbfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .result_i    (parse_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign kind_o       = out_res.kind;
  assign data_byte_o  = out_res.data_byte;
  assign byte_index_o = out_res.byte_index;
  assign msg_class_o  = out_res.msg_class;
  assign msg_id_o     = out_res.msg_id;

endmodule

### hdl/gbfp_parser.sv
// Frame state, Fletcher sums, length registers and per-byte result logic.
module gbfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output gbfp_pkg::result_t result_o
);
  import gbfp_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN1, PH_LEN2, PH_PAYLOAD, PH_CHECK2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d, id_q, id_d, len_low_q, len_low_d;
  logic [7:0]  check1_q, check1_d;
  logic [15:0] frame_len_q, frame_len_d, wanted_q, wanted_d;
  logic [15:0] count_q, count_d;
  logic [15:0] long_len_q, short_len_q;
  logic [7:0]  add_a, add_b;
  logic [15:0] len_full;

  assign add_a    = sum_a_q + rx_byte_i;
  assign add_b    = sum_b_q + add_a;
  assign len_full = {rx_byte_i, len_low_q};

  always_comb begin
    phase_d     = phase_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    class_d     = class_q;
    id_d        = id_q;
    len_low_d   = len_low_q;
    check1_d    = check1_q;
    frame_len_d = frame_len_q;
    wanted_d    = wanted_q;
    count_d     = count_q;
    result_o            = '0;
    result_o.kind       = KIND_PAYLOAD;
    result_o.msg_class  = class_q;
    result_o.msg_id     = id_q;
    if (accept_i) begin
      case (phase_q)
        PH_SYNC1: begin
          if (rx_byte_i == SyncFirst) begin
            sum_a_d = '0;
            sum_b_d = '0;
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx_byte_i == SyncSecond) phase_d = PH_CLASS;
        end
        PH_CLASS: begin
          class_d = rx_byte_i;
          sum_a_d = add_a;
          sum_b_d = add_b;
          phase_d = PH_ID;
        end
        PH_ID: begin
          id_d    = rx_byte_i;
          sum_a_d = add_a;
          sum_b_d = add_b;
          if (rx_byte_i == IdLong) begin
            wanted_d = long_len_q;
            phase_d  = PH_LEN1;
          end else if (rx_byte_i == IdShort) begin
            wanted_d = short_len_q;
            phase_d  = PH_LEN1;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_LEN1: begin
          len_low_d = rx_byte_i;
          sum_a_d   = add_a;
          sum_b_d   = add_b;
          phase_d   = PH_LEN2;
        end
        PH_LEN2: begin
          frame_len_d = len_full;
          sum_a_d     = add_a;
          sum_b_d     = add_b;
          if (len_full == wanted_q) begin
            count_d = '0;
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_PAYLOAD: begin
          if (count_q < frame_len_q) begin
            sum_a_d             = add_a;
            sum_b_d             = add_b;
            result_o.valid      = 1'b1;
            result_o.kind       = KIND_PAYLOAD;
            result_o.data_byte  = rx_byte_i;
            result_o.byte_index = count_q;
            count_d             = count_q + 16'd1;
          end else begin
            check1_d = rx_byte_i;
            phase_d  = PH_CHECK2;
          end
        end
        PH_CHECK2: begin
          result_o.valid = 1'b1;
          result_o.kind  = ((check1_q == sum_a_q) && (rx_byte_i == sum_b_q)) ?
                           KIND_GOOD : KIND_BAD;
          phase_d        = PH_SYNC1;
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      class_q     <= '0;
      id_q        <= '0;
      len_low_q   <= '0;
      check1_q    <= '0;
      frame_len_q <= '0;
      wanted_q    <= '0;
      count_q     <= '0;
      long_len_q  <= LongLenReset;
      short_len_q <= ShortLenReset;
    end else begin
      phase_q     <= phase_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      class_q     <= class_d;
      id_q        <= id_d;
      len_low_q   <= len_low_d;
      check1_q    <= check1_d;
      frame_len_q <= frame_len_d;
      wanted_q    <= wanted_d;
      count_q     <= count_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LONG_LEN:  long_len_q  <= cfg_data_i;
          CFG_SHORT_LEN: short_len_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

### hdl/gbfp_out_reg.sv
// Result register between the parser and the output channel.
module gbfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gbfp_pkg::result_t result_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gbfp_pkg::result_t result_o
);
  import gbfp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;
  logic    load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o && result_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= result_i;
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

### test/gnss_binary_frame_parser_top_tb.sv
// Self-checking testbench for the GNSS binary frame parser: byte stream in, checked results out.
module gnss_binary_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbfp_pkg::*;

  localparam int CycleLimit = 400_000;

  typedef enum logic [2:0] {
    HuntSyncA, HuntSyncB, TakeClass, TakeId, TakeLenLow, TakeLenHigh, TakePayload, TakeCheckB
  } parse_state_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] byte_index_o;
  logic [7:0]  msg_class_o;
  logic [7:0]  msg_id_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_LONG_LEN;
  logic [15:0] cfg_data_i = 16'h0000;

  gnss_binary_frame_parser_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .msg_class_o  (msg_class_o),
    .msg_id_o     (msg_id_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]   rx_stream_q[$];
  result_t      parser_outputs_q[$];
  result_t      oldest_output;
  int           send_idle_pct = 15;
  int           recv_idle_pct = 86;
  int           mismatches = 0;
  int           cycles = 0;

  logic [15:0]  cfg_long_len = LongLenReset;
  logic [15:0]  cfg_short_len = ShortLenReset;

  parse_state_e hunt_state = HuntSyncA;
  logic [7:0]   sum_a = '0;
  logic [7:0]   sum_b = '0;
  logic [7:0]   cur_class = '0;
  logic [7:0]   cur_id = '0;
  logic [7:0]   len_low = '0;
  logic [15:0]  cur_len = '0;
  logic [15:0]  latched_len = '0;
  logic [15:0]  payload_seen = '0;
  logic [7:0]   check_a = '0;

  function automatic void fold_sum(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (hunt_state)
      HuntSyncA: begin
        if (b == SyncFirst) begin
          sum_a = '0;
          sum_b = '0;
          hunt_state = HuntSyncB;
        end
      end
      HuntSyncB: begin
        if (b == SyncSecond) hunt_state = TakeClass;
      end
      TakeClass: begin
        cur_class = b;
        fold_sum(b);
        hunt_state = TakeId;
      end
      TakeId: begin
        cur_id = b;
        fold_sum(b);
        if (b == IdLong) begin
          latched_len = cfg_long_len;
          hunt_state = TakeLenLow;
        end else if (b == IdShort) begin
          latched_len = cfg_short_len;
          hunt_state = TakeLenLow;
        end else begin
          hunt_state = HuntSyncA;
        end
      end
      TakeLenLow: begin
        len_low = b;
        fold_sum(b);
        hunt_state = TakeLenHigh;
      end
      TakeLenHigh: begin
        cur_len = {b, len_low};
        fold_sum(b);
        if (cur_len == latched_len) begin
          payload_seen = '0;
          hunt_state = TakePayload;
        end else begin
          hunt_state = HuntSyncA;
        end
      end
      TakePayload: begin
        if (payload_seen < cur_len) begin
          fold_sum(b);
          r.valid = 1'b1;
          r.kind = KIND_PAYLOAD;
          r.data_byte = b;
          r.byte_index = payload_seen;
          payload_seen = payload_seen + 16'd1;
        end else begin
          check_a = b;
          hunt_state = TakeCheckB;
        end
      end
      default: begin
        r.valid = 1'b1;
        r.kind = (check_a == sum_a && b == sum_b) ? KIND_GOOD : KIND_BAD;
        hunt_state = HuntSyncA;
      end
    endcase
    r.msg_class = cur_class;
    r.msg_id = cur_id;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        oldest_output = parse_byte(rx_byte_i);
        if (oldest_output.valid) parser_outputs_q.push_back(oldest_output);
      end
      if (!in_valid_i || in_ready_o) begin
        if (rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= rx_stream_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  result_t got_want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (parser_outputs_q.size() == 0) begin
          $error("unexpected result: kind %0d data %0h index %0d", kind_o, data_byte_o,
                 byte_index_o);
          mismatches++;
        end else begin
          got_want = parser_outputs_q.pop_front();
          if (kind_o !== got_want.kind) begin
            $error("kind: expected %0d, got %0d", got_want.kind, kind_o);
            mismatches++;
          end
          if (data_byte_o !== got_want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", got_want.data_byte, data_byte_o);
            mismatches++;
          end
          if (byte_index_o !== got_want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", got_want.byte_index, byte_index_o);
            mismatches++;
          end
          if (msg_class_o !== got_want.msg_class) begin
            $error("msg_class: expected %0h, got %0h", got_want.msg_class, msg_class_o);
            mismatches++;
          end
          if (msg_id_o !== got_want.msg_id) begin
            $error("msg_id: expected %0h, got %0h", got_want.msg_id, msg_id_o);
            mismatches++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("gnss_binary_frame_parser_top_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LONG_LEN) cfg_long_len = val;
    else cfg_short_len = val;
  endtask

  // fill below zero means random payload bytes
  task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len_field, input int n_payload,
                             input int fill, input bit spoil, input int sync_gap);
    logic [7:0] body[$];
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] b;
    body.push_back(cls);
    body.push_back(id);
    body.push_back(len_field[7:0]);
    body.push_back(len_field[15:8]);
    for (int i = 0; i < n_payload; i++) body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    ca = '0;
    cb = '0;
    foreach (body[i]) begin
      ca = ca + body[i];
      cb = cb + ca;
    end
    if (spoil) begin
      if ($urandom_range(1)) ca = ca ^ (8'h01 << $urandom_range(7));
      else cb = cb ^ (8'h01 << $urandom_range(7));
    end
    rx_stream_q.push_back(SyncFirst);
    repeat (sync_gap) begin
      b = 8'($urandom);
      if (b == SyncSecond) b = 8'h00;
      rx_stream_q.push_back(b);
    end
    rx_stream_q.push_back(SyncSecond);
    foreach (body[i]) rx_stream_q.push_back(body[i]);
    rx_stream_q.push_back(ca);
    rx_stream_q.push_back(cb);
  endtask

  task automatic run_random(input int target);
    int          made;
    int          pick;
    logic [7:0]  id;
    logic [15:0] want;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      id = $urandom_range(1) ? IdLong : IdShort;
      want = (id == IdLong) ? cfg_long_len : cfg_short_len;
      // keep long payloads rare
      if (want > 32 && $urandom_range(9) != 0) begin
        id = (id == IdLong) ? IdShort : IdLong;
        want = (id == IdLong) ? cfg_long_len : cfg_short_len;
      end
      if (pick < 70 && want <= 96) begin
        queue_frame(8'($urandom), id, want, want, -1, $urandom_range(4) == 0,
                    $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
        made += want + 8;
      end else if (pick < 80) begin
        id = 8'($urandom);
        if (id == IdLong || id == IdShort) id = id ^ 8'h80;
        queue_frame(8'($urandom), id, 16'($urandom), 0, -1, 1'b0, 0);
        made += 8;
      end else if (pick < 92) begin
        queue_frame(8'($urandom), id, want + 16'($urandom_range(1, 300)), 0, -1, 1'b0, 0);
        made += 8;
      end else begin
        repeat ($urandom_range(1, 6)) rx_stream_q.push_back(8'($urandom));
      end
    end
  endtask

  task automatic drain;
    while (rx_stream_q.size() != 0 || in_valid_i || parser_outputs_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] carry_q[$];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_LONG_LEN, 16'd1);
    write_reg(CFG_SHORT_LEN, 16'd0);

    rx_stream_q.push_back(8'h00);
    rx_stream_q.push_back(8'hFF);
    rx_stream_q.push_back(SyncSecond);
    queue_frame(8'h00, IdLong, 16'd1, 1, 8'hFF, 1'b0, 0);
    queue_frame(8'hFF, IdShort, 16'd0, 0, -1, 1'b0, 2);
    queue_frame(8'h05, IdShort, 16'd0, 0, -1, 1'b1, 0);
    queue_frame(8'h80, IdLong, 16'd1, 1, 8'h00, 1'b1, 0);
    queue_frame(8'h01, 8'h03, 16'd1, 0, -1, 1'b0, 0);
    queue_frame(8'h01, IdLong, 16'h0100, 0, -1, 1'b0, 0);
    run_random(110);

    // stop mid-frame after the id byte, rewrite lengths, then finish the frame
    queue_frame(8'h42, IdLong, 16'd1, 1, -1, 1'b0, 0);
    repeat (5) carry_q.push_front(rx_stream_q.pop_back());
    drain();
    write_reg(CFG_LONG_LEN, 16'hFFFF);
    write_reg(CFG_SHORT_LEN, 16'd2);
    send_idle_pct = 86;
    recv_idle_pct = 15;
    foreach (carry_q[i]) rx_stream_q.push_back(carry_q[i]);
    run_random(140);

    drain();
    write_reg(CFG_LONG_LEN, LongLenReset);
    write_reg(CFG_SHORT_LEN, ShortLenReset);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(140);

    drain();
    write_reg(CFG_LONG_LEN, 16'd0);
    write_reg(CFG_SHORT_LEN, 16'hFFFF);
    run_random(140);

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("gnss_binary_frame_parser_top_tb: done, clean");
    end else begin
      $display("gnss_binary_frame_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule
